// File: src/dlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the DDA line rasterizer
// Request and pixel payloads as packed structs, plus request codes.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int PIX_W = 10;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] start_x;
        logic [PIX_W-1:0] start_y;
        logic [PIX_W-1:0] end_x;
        logic [PIX_W-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             last_pixel;
    } t_pix;

endpackage
`default_nettype wire

// File: src/dlr_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_div_lane: bit-serial restoring divider lane
// Computes (mag << FRAC_BITS) / divisor, one quotient bit per shift cycle.
// ----------------------------------------------------------------------------
module dlr_div_lane #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic                  i_shift,
    input  wire logic [COORD_BITS-1:0] i_mag,
    input  wire logic [COORD_BITS-1:0] i_divisor,
    output logic      [FRAC_BITS+1:0]  o_quo
);

    localparam int DVD_BITS = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS = FRAC_BITS + 2;

    logic [DVD_BITS-1:0]   r_dvd;
    logic [COORD_BITS-1:0] r_rem;
    logic [INC_BITS-1:0]   r_quo;

    logic [COORD_BITS:0]   w_trial;
    logic [COORD_BITS+1:0] w_diff;
    logic                  w_fits;

    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_BITS-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, i_divisor};
        w_fits  = !w_diff[COORD_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= {i_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_shift) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
            // remainder stays below the divisor, so it fits COORD_BITS
            r_rem <= w_fits ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            r_quo <= {r_quo[INC_BITS-2:0], w_fits};
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

// File: src/dlr_stepper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_stepper: DDA accumulators and pixel output register
// Holds the line state; each step transfer while a line is active emits one rounded pixel.
// ----------------------------------------------------------------------------
module dlr_stepper
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic [COORD_BITS-1:0] i_sx,
    input  wire logic [COORD_BITS-1:0] i_sy,
    input  wire logic [FRAC_BITS+1:0]  i_inc_x,
    input  wire logic [FRAC_BITS+1:0]  i_inc_y,
    input  wire logic [COORD_BITS:0]   i_count,
    input  wire logic                  i_step,
    output logic                       o_valid,
    output t_pix                       o_pix
);

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS = FRAC_BITS + 2;
    localparam int CNT_BITS = COORD_BITS + 1;
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [CNT_BITS-1:0] ONE  = CNT_BITS'(1);

    logic [ACC_BITS-1:0] r_acc_x, r_acc_y;
    logic [INC_BITS-1:0] r_inc_x, r_inc_y;
    logic [CNT_BITS-1:0] r_count;
    logic                r_active;
    logic                r_valid;
    t_pix                r_pix;

    logic [ACC_BITS-1:0] w_rnd_x, w_rnd_y;
    logic [ACC_BITS-1:0] w_ext_x, w_ext_y;
    logic                w_emit;

    always_comb begin
        w_emit  = i_step && r_active;
        w_rnd_x = r_acc_x + HALF;
        w_rnd_y = r_acc_y + HALF;
        w_ext_x = {{(ACC_BITS-INC_BITS){r_inc_x[INC_BITS-1]}}, r_inc_x};
        w_ext_y = {{(ACC_BITS-INC_BITS){r_inc_y[INC_BITS-1]}}, r_inc_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= w_emit;
            if (i_load) begin
                r_active <= 1'b1;
            end else if (w_emit && r_count == ONE) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc_x <= ACC_BITS'({i_sx, {FRAC_BITS{1'b0}}});
            r_acc_y <= ACC_BITS'({i_sy, {FRAC_BITS{1'b0}}});
            r_inc_x <= i_inc_x;
            r_inc_y <= i_inc_y;
            r_count <= i_count;
        end else if (w_emit) begin
            r_acc_x <= r_acc_x + w_ext_x;
            r_acc_y <= r_acc_y + w_ext_y;
            r_count <= r_count - ONE;
        end
        if (w_emit) begin
            r_pix.pixel_x    <= PIX_W'(w_rnd_x[FRAC_BITS +: COORD_BITS]);
            r_pix.pixel_y    <= PIX_W'(w_rnd_y[FRAC_BITS +: COORD_BITS]);
            r_pix.last_pixel <= (r_count == ONE);
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule
`default_nettype wire

// File: src/dda_line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line rasterizer with bit-serial increment divide
// Step transfer: pixel strobed in the cycle after acceptance while a line is active; one per cycle while not busy.
// Load transfer: busy through the bit-serial divide (ST_DIV), which yields one
//   quotient bit per cycle, and ST_FIN, which loads the stepper.
// Synchronous active-low reset leaves the block idle with no line active.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_pix      o_pix
);

    localparam int DIV_CYC  = COORD_BITS + FRAC_BITS;
    localparam int CYC_BITS = $clog2(DIV_CYC + 1);
    localparam int INC_BITS = FRAC_BITS + 2;
    localparam int CNT_BITS = COORD_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [CYC_BITS-1:0]   r_cyc,   n_cyc;
    logic [COORD_BITS-1:0] r_sx, r_sy;
    logic                  r_neg_x, r_neg_y;
    logic [COORD_BITS-1:0] r_steps;

    logic                  w_accept, w_load, w_step, w_fin;
    logic [COORD_BITS-1:0] w_sx, w_sy, w_ex, w_ey;
    logic [COORD_BITS:0]   w_dx, w_dy, w_dxn, w_dyn;
    logic [COORD_BITS-1:0] w_ax, w_ay, w_steps;
    logic [INC_BITS-1:0]   w_qx, w_qy, w_inc_x, w_inc_y;
    logic [CNT_BITS-1:0]   w_count;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        w_accept = start && !busy;
        w_load   = w_accept && (i_req.req_type == REQ_LOAD);
        w_step   = w_accept && (i_req.req_type == REQ_STEP);
        w_fin    = (r_state == ST_FIN);

        w_sx  = COORD_BITS'(i_req.start_x);
        w_sy  = COORD_BITS'(i_req.start_y);
        w_ex  = COORD_BITS'(i_req.end_x);
        w_ey  = COORD_BITS'(i_req.end_y);
        w_dx  = {1'b0, w_ex} - {1'b0, w_sx};
        w_dy  = {1'b0, w_ey} - {1'b0, w_sy};
        w_dxn = -w_dx;
        w_dyn = -w_dy;
        w_ax  = w_dx[COORD_BITS] ? w_dxn[COORD_BITS-1:0] : w_dx[COORD_BITS-1:0];
        w_ay  = w_dy[COORD_BITS] ? w_dyn[COORD_BITS-1:0] : w_dy[COORD_BITS-1:0];
        w_steps = (w_ax > w_ay) ? w_ax : w_ay;

        // zero-length line: divisor is zero, force both increments to zero
        if (r_steps == '0) begin
            w_inc_x = '0;
            w_inc_y = '0;
        end else begin
            w_inc_x = r_neg_x ? -w_qx : w_qx;
            w_inc_y = r_neg_y ? -w_qy : w_qy;
        end
        w_count = {1'b0, r_steps} + CNT_BITS'(1);
    end

    always_comb begin
        n_state = r_state;
        n_cyc   = r_cyc;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_DIV;
                    n_cyc   = CYC_BITS'(DIV_CYC - 1);
                end
            end
            ST_DIV: begin
                n_cyc = r_cyc - CYC_BITS'(1);
                if (r_cyc == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cyc   <= '0;
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
        end
    end

    // capture start point, step count and sign data on a load transfer
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sx    <= w_sx;
            r_sy    <= w_sy;
            r_neg_x <= w_dx[COORD_BITS];
            r_neg_y <= w_dy[COORD_BITS];
            r_steps <= w_steps;
        end
    end

    dlr_div_lane #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_shift   (r_state == ST_DIV),
        .i_mag     (w_ax),
        .i_divisor (r_steps),
        .o_quo     (w_qx)
    );

    dlr_div_lane #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_shift   (r_state == ST_DIV),
        .i_mag     (w_ay),
        .i_divisor (r_steps),
        .o_quo     (w_qy)
    );

    dlr_stepper #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_stepper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fin),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .i_inc_x (w_inc_x),
        .i_inc_y (w_inc_y),
        .i_count (w_count),
        .i_step  (w_step),
        .o_valid (o_valid),
        .o_pix   (o_pix)
    );

endmodule
`default_nettype wire

// File: test/dlr_checker.sv
// ----------------------------------------------------------------------------
// dlr_checker: pixel predictor and scoreboard for the DDA line rasterizer
// Watches request and pixel transfers, keeps its own copy of the line state,
// queues the pixel each step request should produce and compares in order.
// ----------------------------------------------------------------------------
module dlr_checker
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_req i_req,
    input  wire logic i_valid,
    input  wire t_pix i_pix,
    output int        o_errors,
    output int        o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int CNT_W = COORD_BITS + 1;

    logic [ACC_W-1:0] acc_x, acc_y;
    logic [INC_W-1:0] inc_x, inc_y;
    logic [CNT_W-1:0] pixels_left;
    bit               line_active;
    t_pix             pixel_queue[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // delta * 2^FRAC_BITS / steps on magnitudes, truncated, sign applied after
    function automatic logic [INC_W-1:0] scale_delta(input int delta, input int steps);
        logic [63:0] quo;
        if (steps == 0)
            return '0;
        quo = (64'(delta < 0 ? -delta : delta) << FRAC_BITS) / 64'(steps);
        if (delta < 0)
            quo = -quo;
        return quo[INC_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] round_half_up(input logic [ACC_W-1:0] acc);
        logic [63:0] sum;
        sum = 64'(acc) + (64'd1 << (FRAC_BITS - 1));
        return PIX_W'(sum >> FRAC_BITS);
    endfunction

    function automatic void load_line(input t_req r);
        int dx, dy, steps;
        dx = int'(r.end_x[COORD_BITS-1:0]) - int'(r.start_x[COORD_BITS-1:0]);
        dy = int'(r.end_y[COORD_BITS-1:0]) - int'(r.start_y[COORD_BITS-1:0]);
        steps = (dx < 0 ? -dx : dx);
        if ((dy < 0 ? -dy : dy) > steps)
            steps = (dy < 0 ? -dy : dy);
        inc_x       = scale_delta(dx, steps);
        inc_y       = scale_delta(dy, steps);
        acc_x       = ACC_W'(64'(r.start_x[COORD_BITS-1:0]) << FRAC_BITS);
        acc_y       = ACC_W'(64'(r.start_y[COORD_BITS-1:0]) << FRAC_BITS);
        pixels_left = CNT_W'(steps + 1);
        line_active = 1'b1;
    endfunction

    function automatic bit next_pixel(output t_pix p);
        p = '0;
        if (!line_active)
            return 1'b0;
        p.pixel_x    = round_half_up(acc_x);
        p.pixel_y    = round_half_up(acc_y);
        p.last_pixel = (pixels_left == CNT_W'(1));
        acc_x = acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
        acc_y = acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
        pixels_left = pixels_left - 1'b1;
        if (pixels_left == '0)
            line_active = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pix want;
        if (!i_rst_n) begin
            acc_x       = '0;
            acc_y       = '0;
            inc_x       = '0;
            inc_y       = '0;
            pixels_left = '0;
            line_active = 1'b0;
            pixel_queue.delete();
        end else begin
            // check the pixel transfer first: it belongs to an earlier request
            if (i_valid) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel: x=%0d y=%0d last=%0b",
                           i_pix.pixel_x, i_pix.pixel_y, i_pix.last_pixel);
                    o_errors++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_pix.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, i_pix.pixel_x);
                        o_errors++;
                    end
                    if (i_pix.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, i_pix.pixel_y);
                        o_errors++;
                    end
                    if (i_pix.last_pixel !== want.last_pixel) begin
                        $error("last_pixel: expected %0b, got %0b",
                               want.last_pixel, i_pix.last_pixel);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_req.req_type == REQ_LOAD)
                    load_line(i_req);
                else if (next_pixel(want))
                    pixel_queue.push_back(want);
            end
        end
        o_pending = pixel_queue.size();
    end

endmodule

// File: test/dda_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb: request stimulus for the DDA line rasterizer
// Directed lines (zero length, extremes, both directions, aborts, idle steps)
// then random lines, mostly short, with random gaps; dlr_checker scores the pixels.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

    import dlr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 500;
    localparam int COORD_MAX    = 1023;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_pix o_pix;
    int   errors;
    int   pending;
    int   idle_run = 0;
    int   pixels_left = 0;
    int   live_items = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dda_line_rasterizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_pix   (o_pix)
    );

    dlr_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_valid   (o_valid),
        .i_pix     (o_pix),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int clamp_coord(input int v);
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    function automatic int line_length(input int sx, input int sy, input int ex, input int ey);
        int ax, ay;
        ax = ex > sx ? ex - sx : sx - ex;
        ay = ey > sy ? ey - sy : sy - ey;
        return (ax > ay ? ax : ay) + 1;
    endfunction

    // hold start high across back-to-back items; drop it only for a gap
    task automatic send_item(input t_req r, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        if (r.req_type == REQ_LOAD) begin
            pixels_left = line_length(r.start_x, r.start_y, r.end_x, r.end_y);
            live_items++;
        end else if (pixels_left > 0) begin
            pixels_left--;
            live_items++;
        end
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey,
                             input int gap);
        t_req r;
        r.req_type = REQ_LOAD;
        r.start_x  = PIX_W'(sx);
        r.start_y  = PIX_W'(sy);
        r.end_x    = PIX_W'(ex);
        r.end_y    = PIX_W'(ey);
        send_item(r, gap);
    endtask

    // step requests carry random coordinates, which the block ignores
    task automatic step_line(input int count, input bit burst);
        t_req r;
        repeat (count) begin
            r = t_req'({$urandom, $urandom});
            r.req_type = REQ_STEP;
            send_item(r, burst ? 0 : $urandom_range(0, 16));
        end
    endtask

    task automatic drain_pixels();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin
        int sx, sy, ex, ey, npix, count;
        bit burst;
        t_req r;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle step, zero length, extremes, aborts, reversed axes
        step_line(1, 1'b0);
        load_line(7, 7, 7, 7, 0);
        step_line(2, 1'b1);
        load_line(0, 0, COORD_MAX, COORD_MAX, 3);
        step_line(2, 1'b1);
        load_line(COORD_MAX, 0, 0, COORD_MAX, 0);
        step_line(1, 1'b0);
        load_line(5, 12, 5, 8, 1);
        step_line(5, 1'b1);
        load_line(9, 3, 6, 3, 0);
        step_line(4, 1'b0);
        load_line(2, 1, 5, 3, 2);
        step_line(4, 1'b1);

        // pause until every pixel has arrived before going random
        drain_pixels();
        live_items = 0;

        while (live_items < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary request mix
                repeat ($urandom_range(1, 4)) begin
                    r = t_req'({$urandom, $urandom});
                    send_item(r, burst ? 0 : $urandom_range(0, 16));
                end
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    sx = $urandom_range(0, COORD_MAX);
                    sy = $urandom_range(0, COORD_MAX);
                    ex = $urandom_range(0, COORD_MAX);
                    ey = $urandom_range(0, COORD_MAX);
                end else begin
                    sx = $urandom_range(0, COORD_MAX);
                    sy = $urandom_range(0, COORD_MAX);
                    ex = clamp_coord(sx + $urandom_range(0, 24) - 12);
                    ey = clamp_coord(sy + $urandom_range(0, 24) - 12);
                end
                if ($urandom_range(0, 7) == 0)
                    drain_pixels();
                load_line(sx, sy, ex, ey, burst ? 0 : $urandom_range(0, 16));
                npix = line_length(sx, sy, ex, ey);
                case ($urandom_range(0, 7))
                    0: count = $urandom_range(0, npix - 1);
                    1: count = npix + $urandom_range(1, 3);
                    default: count = npix;
                endcase
                // keep long lines short of completion
                if (count > 48)
                    count = $urandom_range(1, 48);
                step_line(count, burst);
            end
        end

        drain_pixels();
        repeat (40) @(negedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
